// ----- hdl/bbc_pkg.sv -----
// Shared types, constants and helpers for the binary/BCD converter.
package bbc_pkg;

    localparam int VALUE_W    = 24;
    localparam int NIB_W      = 4;
    localparam int NIBS       = VALUE_W / NIB_W;
    localparam int DIGITS_DEF = 6;
    localparam int LIMIT_W    = 40;

    // reciprocal of ten, exact for operands below 2**26
    localparam int RECIP_SHIFT = 27;
    localparam logic [VALUE_W-1:0] RECIP_TEN = VALUE_W'(((64'd1 << RECIP_SHIFT) + 64'd9) / 64'd10);

    typedef enum logic {
        KIND_TO_BCD   = 1'b0,
        KIND_FROM_BCD = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic               clamped;
        logic [VALUE_W-1:0] work;   // quotient left to split, or running sum
        logic [VALUE_W-1:0] bcd;    // digits so far, or raw nibbles
    } t_stage;

    function automatic logic [LIMIT_W-1:0] amount_limit(input int digits);
        logic [LIMIT_W-1:0] lim;
        lim = LIMIT_W'(1);
        for (int d = 0; d < digits; d++) begin
            lim = LIMIT_W'(lim * LIMIT_W'(10));
        end
        return LIMIT_W'(lim - LIMIT_W'(1));
    endfunction

    function automatic logic [VALUE_W-1:0] limit_bcd(input int digits);
        logic [VALUE_W-1:0] pat;
        pat = '0;
        for (int d = 0; d < NIBS; d++) begin
            if (d < digits) begin
                pat[d*NIB_W +: NIB_W] = NIB_W'(9);
            end
        end
        return pat;
    endfunction

endpackage

// ----- hdl/bbc_clamp.sv -----
// Entry stage: clamps binary amounts and sets up the digit pipeline.
module bbc_clamp
    import bbc_pkg::*;
#(
    parameter int DIGITS = DIGITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic               i_kind,
    input  logic [VALUE_W-1:0] i_value,
    output logic               o_valid,
    output t_stage             o_stage
);

    localparam logic [LIMIT_W-1:0] LIMIT = amount_limit(DIGITS);

    logic   r_valid;
    t_stage r_stage;
    t_stage n_stage;
    logic   over;

    assign over = {{(LIMIT_W-VALUE_W){1'b0}}, i_value} > LIMIT;

    always_comb begin
        n_stage.kind = t_kind'(i_kind);
        if (t_kind'(i_kind) == KIND_TO_BCD) begin
            n_stage.clamped = over;
            n_stage.work    = over ? LIMIT[VALUE_W-1:0] : i_value;
            n_stage.bcd     = '0;
        end else begin
            n_stage.clamped = 1'b0;
            n_stage.work    = '0;
            n_stage.bcd     = i_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;

endmodule

// ----- hdl/bbc_digit.sv -----
// One digit stage: splits off a decimal digit or takes one Horner step.
module bbc_digit
    import bbc_pkg::*;
#(
    parameter int DIGITS = DIGITS_DEF,
    parameter int IDX    = 0
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_en,
    input  logic   i_valid,
    input  t_stage i_stage,
    output logic   o_valid,
    output t_stage o_stage
);

    localparam int NIB = DIGITS - 1 - IDX;

    logic   r_valid;
    t_stage r_stage;
    t_stage n_stage;

    logic [2*VALUE_W-1:0] prod;
    logic [VALUE_W-1:0]   quot;
    logic [VALUE_W-1:0]   quot10;
    logic [VALUE_W-1:0]   rem;
    logic [VALUE_W-1:0]   sum10;
    logic [NIB_W-1:0]     nib;
    logic [VALUE_W-1:0]   digits_new;

    assign prod   = i_stage.work * RECIP_TEN;
    assign quot   = VALUE_W'(prod >> RECIP_SHIFT);
    assign quot10 = VALUE_W'({quot, 3'b000}) + VALUE_W'({quot, 1'b0});
    assign rem    = VALUE_W'(i_stage.work - quot10);
    assign sum10  = VALUE_W'({i_stage.work, 3'b000}) + VALUE_W'({i_stage.work, 1'b0});

    generate
        if (NIB < NIBS) begin : g_nib
            assign nib = i_stage.bcd[NIB*NIB_W +: NIB_W];
        end else begin : g_no_nib
            assign nib = '0;
        end
        if (IDX < NIBS) begin : g_put
            always_comb begin
                digits_new = i_stage.bcd;
                digits_new[IDX*NIB_W +: NIB_W] = rem[NIB_W-1:0];
            end
        end else begin : g_drop
            assign digits_new = i_stage.bcd;
        end
    endgenerate

    always_comb begin
        n_stage = i_stage;
        unique case (i_stage.kind)
            KIND_TO_BCD: begin
                n_stage.work = quot;
                n_stage.bcd  = digits_new;
            end
            KIND_FROM_BCD: begin
                n_stage.work = VALUE_W'(sum10 + {{(VALUE_W-NIB_W){1'b0}}, nib});
            end
            default: begin
                n_stage = i_stage;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;

endmodule

// ----- hdl/binary_bcd_converter_core.sv -----
// An accepted word reaches o_valid after passing the clamp register and every digit register.
// Throughput: one word per cycle while the output is not stalled; one clamp stage, then one stage per decimal digit.
// A word held at the output with i_ready low stalls the whole pipe; nothing is lost.
// Reset (synchronous, active low) clears all stage valid bits; data is not reset.
// Top level of the binary/BCD converter pipeline.
module binary_bcd_converter_core
    import bbc_pkg::*;
#(
    parameter int DIGITS = DIGITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_kind,
    input  logic [VALUE_W-1:0] i_value,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [VALUE_W-1:0] o_result,
    output logic               o_clamped
);

    logic   en;
    logic   vld [DIGITS+1];
    t_stage stg [DIGITS+1];

    assign en = !vld[DIGITS] || i_ready;

    bbc_clamp #(
        .DIGITS (DIGITS)
    ) u_clamp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_kind  (i_kind),
        .i_value (i_value),
        .o_valid (vld[0]),
        .o_stage (stg[0])
    );

    generate
        for (genvar g = 0; g < DIGITS; g++) begin : g_dig
            bbc_digit #(
                .DIGITS (DIGITS),
                .IDX    (g)
            ) u_digit (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (en),
                .i_valid (vld[g]),
                .i_stage (stg[g]),
                .o_valid (vld[g+1]),
                .o_stage (stg[g+1])
            );
        end
    endgenerate

    assign o_ready   = en;
    assign o_valid   = vld[DIGITS];
    assign o_result  = (stg[DIGITS].kind == KIND_FROM_BCD) ? stg[DIGITS].work
                                                           : stg[DIGITS].bcd;
    assign o_clamped = stg[DIGITS].clamped;

endmodule

// ----- hdl/bbc_checker.sv -----
// Port-level assertions for the converter, bound to the top level.
module bbc_checker
    import bbc_pkg::*;
#(
    parameter int DIGITS = DIGITS_DEF
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_ready,
    input logic               o_valid,
    input logic               i_ready,
    input logic [VALUE_W-1:0] o_result,
    input logic               o_clamped
);

    localparam logic [VALUE_W-1:0] CLAMP_BCD = limit_bcd(DIGITS);

    // held word must not change
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_result) && $stable(o_clamped))
        else $error("output word changed while stalled");

    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid && !i_ready)
        else $error("input stalled without output back-pressure");

    a_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_clamped |-> o_result == CLAMP_BCD)
        else $error("clamped word is not the largest amount");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

bind binary_bcd_converter_core bbc_checker #(
    .DIGITS (DIGITS)
) u_bbc_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .o_ready   (o_ready),
    .o_valid   (o_valid),
    .i_ready   (i_ready),
    .o_result  (o_result),
    .o_clamped (o_clamped)
);

// ----- tb/sv/binary_bcd_converter_core_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the binary/BCD converter core, both directions.
module binary_bcd_converter_core_tb;
    import bbc_pkg::*;

    localparam int DIGITS       = DIGITS_DEF;
    localparam int LATENCY      = DIGITS + 1;
    localparam longint AMOUNT_MAX = 10 ** DIGITS - 1;
    localparam int PHASE_WORDS  = 700;
    localparam int LAST_WORDS   = 600;
    localparam int HOLD_AT      = 300;
    localparam int HOLD_LEN     = 400;
    localparam int CYCLE_LIMIT  = 200000;

    typedef struct packed {
        logic [VALUE_W-1:0] result;
        logic               clamped;
    } t_conversion;

    class conversion_tracker;
        t_conversion pending[$];
        int errors;
        int checked;
        int n_to_bcd;
        int n_from_bcd;
        int n_clamped;

        function new();
            errors     = 0;
            checked    = 0;
            n_to_bcd   = 0;
            n_from_bcd = 0;
            n_clamped  = 0;
        endfunction

        function t_conversion convert_word(t_kind kind, logic [VALUE_W-1:0] value);
            t_conversion c;
            logic [63:0] amount;
            logic [63:0] acc;
            logic [63:0] weight;
            logic [63:0] nibbles;
            c.clamped = 1'b0;
            acc = '0;
            if (kind == KIND_TO_BCD) begin
                amount = 64'(value);
                if (amount > 64'(AMOUNT_MAX)) begin
                    amount = 64'(AMOUNT_MAX);
                    c.clamped = 1'b1;
                end
                for (int d = 0; d < DIGITS; d++) begin
                    acc = acc | ((amount % 64'd10) << (NIB_W * d));
                    amount = amount / 64'd10;
                end
            end else begin
                nibbles = 64'(value);
                weight = 64'd1;
                for (int d = 0; d < DIGITS; d++) begin
                    acc = acc + weight * (nibbles & 64'hF);
                    nibbles = nibbles >> NIB_W;
                    weight = weight * 64'd10;
                end
            end
            c.result = acc[VALUE_W-1:0];
            return c;
        endfunction

        function void note_input(t_kind kind, logic [VALUE_W-1:0] value);
            t_conversion c;
            c = convert_word(kind, value);
            pending.push_back(c);
            if (kind == KIND_TO_BCD) begin
                n_to_bcd++;
            end else begin
                n_from_bcd++;
            end
            if (c.clamped) begin
                n_clamped++;
            end
        endfunction

        function void check_output(logic [VALUE_W-1:0] result, logic clamped);
            t_conversion want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected word, result %06h clamped %b", $time, result, clamped);
                errors++;
                return;
            end
            want = pending.pop_front();
            checked++;
            if (result !== want.result) begin
                $display("%0t: result mismatch, expected %06h, actual %06h",
                         $time, want.result, result);
                errors++;
            end
            if (clamped !== want.clamped) begin
                $display("%0t: clamped mismatch, expected %b, actual %b",
                         $time, want.clamped, clamped);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               i_kind  = 1'b0;
    logic [VALUE_W-1:0] i_value = '0;
    logic               i_ready = 1'b0;
    logic               o_ready;
    logic               o_valid;
    logic [VALUE_W-1:0] o_result;
    logic               o_clamped;

    conversion_tracker tracker = new();
    int cycle_count = 0;
    int words_sent  = 0;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;

    binary_bcd_converter_core #(
        .DIGITS(DIGITS)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_kind(i_kind),
        .i_value(i_value),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_result(o_result),
        .o_clamped(o_clamped)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk);
        $display("%0t: timed out after %0d cycles", $time, cycle_count);
        $display("binary_bcd_converter_core_tb NOT OK");
        $finish;
    end

    // receive side; one long hold-off lets the pipe fill and back up
    initial begin : receive_side
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) begin
                tracker.check_output(o_result, o_clamped);
            end
            if (!hold_done && words_sent >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else if (rx_idle_pct > 0 && $urandom_range(99) < rx_idle_pct) begin
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    task automatic send_word(input t_kind kind, input logic [VALUE_W-1:0] value);
        i_valid <= 1'b1;
        i_kind  <= kind;
        i_value <= value;
        do @(posedge i_clk); while (!o_ready);
        tracker.note_input(kind, value);
        words_sent++;
        while (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            i_kind  <= 1'($urandom_range(1));
            i_value <= VALUE_W'($urandom);
            @(posedge i_clk);
        end
    endtask

    function automatic logic [VALUE_W-1:0] random_amount();
        unique case ($urandom_range(3))
            0: return VALUE_W'($urandom_range(AMOUNT_MAX));
            1: return VALUE_W'($urandom);
            2: return VALUE_W'($urandom_range(AMOUNT_MAX + 10, AMOUNT_MAX - 9));
            default: return VALUE_W'($urandom_range(99));
        endcase
    endfunction

    // mostly proper BCD; some raw words and some with one digit above nine
    function automatic logic [VALUE_W-1:0] random_digits();
        logic [VALUE_W-1:0] v;
        int pick;
        v = '0;
        pick = $urandom_range(3);
        if (pick == 2) begin
            return VALUE_W'($urandom);
        end
        for (int d = 0; d < NIBS; d++) begin
            v[d*NIB_W +: NIB_W] = NIB_W'($urandom_range(9));
        end
        if (pick == 3) begin
            v[$urandom_range(NIBS - 1)*NIB_W +: NIB_W] = NIB_W'($urandom_range(15, 10));
        end
        return v;
    endfunction

    task automatic send_random(input int count);
        t_kind kind;
        for (int n = 0; n < count; n++) begin
            kind = t_kind'($urandom_range(1));
            if (kind == KIND_TO_BCD) begin
                send_word(kind, random_amount());
            end else begin
                send_word(kind, random_digits());
            end
        end
    endtask

    initial begin : stimulus
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        tx_idle_pct <= 11;
        rx_idle_pct <= 50;

        send_word(KIND_TO_BCD, 24'd0);
        send_word(KIND_TO_BCD, 24'd1);
        send_word(KIND_TO_BCD, 24'd9);
        send_word(KIND_TO_BCD, 24'd10);
        send_word(KIND_TO_BCD, 24'd123456);
        send_word(KIND_TO_BCD, 24'd999999);
        send_word(KIND_TO_BCD, 24'd1000000);
        send_word(KIND_TO_BCD, 24'hFFFFFF);
        send_word(KIND_TO_BCD, 24'h800000);
        send_word(KIND_FROM_BCD, 24'h000000);
        send_word(KIND_FROM_BCD, 24'h000009);
        send_word(KIND_FROM_BCD, 24'h123456);
        send_word(KIND_FROM_BCD, 24'h999999);
        send_word(KIND_FROM_BCD, 24'h100000);
        send_word(KIND_FROM_BCD, 24'h00000A);
        send_word(KIND_FROM_BCD, 24'hA00000);
        send_word(KIND_FROM_BCD, 24'hF0F0F0);
        send_word(KIND_FROM_BCD, 24'hFFFFFF);

        send_random(PHASE_WORDS);
        tx_idle_pct <= 50;
        rx_idle_pct <= 11;
        send_random(PHASE_WORDS);
        tx_idle_pct <= 0;
        rx_idle_pct <= 0;
        send_random(LAST_WORDS);
        i_valid <= 1'b0;

        while (tracker.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);

        $display("Converted %0d words: %0d to BCD (%0d clamped), %0d from BCD.",
                 tracker.checked, tracker.n_to_bcd, tracker.n_clamped, tracker.n_from_bcd);
        $display("Idling on both sides, one %0d-cycle output hold-off, %0d errors.",
                 HOLD_LEN, tracker.errors);
        if (tracker.errors == 0) begin
            $display("binary_bcd_converter_core_tb OK");
        end else begin
            $display("binary_bcd_converter_core_tb NOT OK");
        end
        $finish;
    end

endmodule
